[rtl/llti_pkg.sv]
package llti_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned CRD_W = 32;
  localparam int unsigned TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

  // log2 value: 5-bit signed integer part, 16 fraction bits
  localparam int unsigned LOG_W = 21;
  localparam int unsigned NUM_W = 2 * LOG_W;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_FEW   = 3'd2,
    ST_FULL  = 3'd3,
    ST_ZERO  = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [CRD_W-1:0] x_value;
    logic [CRD_W-1:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic [CRD_W-1:0] result_value;
    logic [2:0]       status;
  } out_item_t;

  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic [CRD_W-1:0] x1;
    logic [CRD_W-1:0] x2;
    logic [CRD_W-1:0] xq;
    logic [CRD_W-1:0] y1;
    logic [CRD_W-1:0] y2;
  } math_req_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    n    = n_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bitv > n) bitv = bitv >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv != 64'd0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-k) in Q1.31, each root taken from the previous one
  function automatic logic [31:0] exp_root(input int k);
    logic [63:0] r;
    r = 64'd1 << 32;
    for (int j = 1; j <= k; j++) begin
      r = isqrt64(r << 31);
    end
    return r[31:0];
  endfunction

endpackage

[rtl/llti_cell.sv]
module llti_cell (
  input  logic            clk_i,
  input  logic            valid_i,
  input  logic            ins_i,
  input  llti_pkg::point_t new_i,
  input  logic            prev_gt_i,
  input  llti_pkg::point_t prev_i,
  output llti_pkg::point_t pt_o,
  output logic            gt_o,
  output logic            ge_o
);

  llti_pkg::point_t pt_q, pt_d;

  // empty cells count as above any x, so the new point lands at the end
  assign gt_o = !valid_i || (pt_q.x > new_i.x);
  assign ge_o = pt_q.x >= new_i.x;
  assign pt_o = pt_q;

  always_comb begin
    pt_d = pt_q;
    if (ins_i && gt_o) begin
      pt_d = prev_gt_i ? prev_i : new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end

endmodule

[rtl/llti_math.sv]
module llti_math (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  llti_pkg::math_req_t    req_i,
  output logic                   done_o,
  output logic [llti_pkg::CRD_W-1:0] result_o
);

  localparam int unsigned LW = llti_pkg::LOG_W;
  localparam int unsigned NW = llti_pkg::NUM_W;

  localparam logic [2:0] OP_X1 = 3'd0;
  localparam logic [2:0] OP_X2 = 3'd1;
  localparam logic [2:0] OP_XQ = 3'd2;
  localparam logic [2:0] OP_Y1 = 3'd3;
  localparam logic [2:0] OP_Y2 = 3'd4;

  localparam logic [31:0] ROOT_K [16] = '{
    llti_pkg::exp_root(1),  llti_pkg::exp_root(2),  llti_pkg::exp_root(3),
    llti_pkg::exp_root(4),  llti_pkg::exp_root(5),  llti_pkg::exp_root(6),
    llti_pkg::exp_root(7),  llti_pkg::exp_root(8),  llti_pkg::exp_root(9),
    llti_pkg::exp_root(10), llti_pkg::exp_root(11), llti_pkg::exp_root(12),
    llti_pkg::exp_root(13), llti_pkg::exp_root(14), llti_pkg::exp_root(15),
    llti_pkg::exp_root(16)
  };

  typedef enum logic [7:0] {
    M_IDLE  = 8'b0000_0001,
    M_NORM  = 8'b0000_0010,
    M_SQR   = 8'b0000_0100,
    M_MUL   = 8'b0000_1000,
    M_DIV   = 8'b0001_0000,
    M_LADD  = 8'b0010_0000,
    M_EXP   = 8'b0100_0000,
    M_SCALE = 8'b1000_0000
  } mstate_e;

  mstate_e         st_q, st_d;
  logic            done_q, done_d;
  logic [2:0]      li_q, li_d;
  logic [2:0]      ns_q, ns_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [31:0]     m_q, m_d;
  logic [4:0]      lz_q, lz_d;
  logic [15:0]     frac_q, frac_d;
  logic [LW-1:0]   lg_q [5];
  logic [LW-1:0]   lg_d [5];
  logic [NW-1:0]   num_q, num_d;
  logic [LW-1:0]   rem_q, rem_d;
  logic [LW-1:0]   den_q, den_d;
  logic            neg_q, neg_d;
  logic [15:0]     f_q, f_d;
  logic [4:0]      n_q, n_d;
  logic [31:0]     acc_q, acc_d;
  logic [31:0]     res_q, res_d;

  logic [31:0]     opnd_next;
  logic [5:0]      sh;
  logic [63:0]     sq;
  logic [32:0]     sq_t;
  logic [15:0]     frac_n;
  logic [LW:0]     dx, dy, dxq, ady;
  logic [LW:0]     rs;
  logic [LW:0]     qs, lres;
  logic [LW-1:0]   u;
  logic [63:0]     eprod;
  logic [32:0]     rnd;

  function automatic logic [31:0] pick(input logic [2:0] idx, input llti_pkg::math_req_t r);
    logic [31:0] v;
    case (idx)
      OP_X1:   v = r.x1;
      OP_X2:   v = r.x2;
      OP_XQ:   v = r.xq;
      OP_Y1:   v = r.y1;
      OP_Y2:   v = r.y2;
      default: v = r.x1;
    endcase
    return v;
  endfunction

  assign opnd_next = pick(li_q + 3'd1, req_i);
  assign sh        = 6'd16 >> ns_q;
  assign sq        = 64'(m_q) * 64'(m_q);
  assign sq_t      = sq[63:31];
  assign frac_n    = {frac_q[14:0], sq_t[32]};
  assign dx        = {lg_q[OP_X2][LW-1], lg_q[OP_X2]} - {lg_q[OP_X1][LW-1], lg_q[OP_X1]};
  assign dy        = {lg_q[OP_Y2][LW-1], lg_q[OP_Y2]} - {lg_q[OP_Y1][LW-1], lg_q[OP_Y1]};
  assign dxq       = {lg_q[OP_XQ][LW-1], lg_q[OP_XQ]} - {lg_q[OP_X1][LW-1], lg_q[OP_X1]};
  assign ady       = dy[LW] ? (~dy + 1'b1) : dy;
  assign rs        = {rem_q, num_q[NW-1]};
  assign qs        = neg_q ? (~{1'b0, num_q[LW-1:0]} + 1'b1) : {1'b0, num_q[LW-1:0]};
  assign lres      = {lg_q[OP_Y1][LW-1], lg_q[OP_Y1]} + qs;
  assign u         = lres[LW-1:0] + (LW'(1) << (LW - 1));
  assign eprod     = 64'(acc_q) * 64'(ROOT_K[cnt_q[3:0]]);
  assign rnd       = {1'b0, acc_q} + (33'd1 << (n_q - 5'd1));

  always_comb begin
    st_d   = st_q;
    done_d = 1'b0;
    li_d   = li_q;
    ns_d   = ns_q;
    cnt_d  = cnt_q;
    m_d    = m_q;
    lz_d   = lz_q;
    frac_d = frac_q;
    lg_d   = lg_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    f_d    = f_q;
    n_d    = n_q;
    acc_d  = acc_q;
    res_d  = res_q;
    case (st_q)
      M_IDLE: begin
        if (start_i) begin
          li_d = OP_X1;
          m_d  = req_i.x1;
          lz_d = '0;
          ns_d = '0;
          st_d = M_NORM;
        end
      end
      M_NORM: begin
        // binary leading-zero search, halving the step each cycle
        if ((m_q >> (6'd32 - sh)) == 32'd0) begin
          m_d  = m_q << sh;
          lz_d = lz_q + sh[4:0];
        end
        if (ns_q == 3'd4) begin
          cnt_d  = '0;
          frac_d = '0;
          st_d   = M_SQR;
        end else begin
          ns_d = ns_q + 3'd1;
        end
      end
      M_SQR: begin
        frac_d = frac_n;
        m_d    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'd15) begin
          lg_d[li_q] = {5'd15 - lz_q, frac_n};
          if (li_q == OP_Y2) begin
            st_d = M_MUL;
          end else begin
            li_d = li_q + 3'd1;
            m_d  = opnd_next;
            lz_d = '0;
            ns_d = '0;
            st_d = M_NORM;
          end
        end
      end
      M_MUL: begin
        if (dx == '0) begin
          res_d  = req_i.y1;
          done_d = 1'b1;
          st_d   = M_IDLE;
        end else begin
          num_d = NW'(ady[LW-1:0]) * NW'(dxq[LW-1:0]);
          neg_d = dy[LW];
          den_d = dx[LW-1:0];
          rem_d = '0;
          cnt_d = '0;
          st_d  = M_DIV;
        end
      end
      M_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rs >= {1'b0, den_q}) begin
          rem_d = LW'(rs - {1'b0, den_q});
          num_d = {num_q[NW-2:0], 1'b1};
        end else begin
          rem_d = rs[LW-1:0];
          num_d = {num_q[NW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(NW - 1)) begin
          st_d = M_LADD;
        end
      end
      M_LADD: begin
        f_d   = u[15:0];
        n_d   = 5'd31 - u[LW-1:16];
        acc_d = 32'h8000_0000;
        cnt_d = '0;
        st_d  = M_EXP;
      end
      M_EXP: begin
        if (f_q[15]) begin
          acc_d = eprod[62:31];
        end
        f_d   = {f_q[14:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd15) begin
          st_d = M_SCALE;
        end
      end
      M_SCALE: begin
        if (n_q == 5'd0) begin
          res_d = acc_q;
        end else begin
          res_d = 32'(rnd >> n_q);
        end
        done_d = 1'b1;
        st_d   = M_IDLE;
      end
      default: st_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    li_q   <= li_d;
    ns_q   <= ns_d;
    cnt_q  <= cnt_d;
    m_q    <= m_d;
    lz_q   <= lz_d;
    frac_q <= frac_d;
    lg_q   <= lg_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    f_q    <= f_d;
    n_q    <= n_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[rtl/log_log_table_interpolator.sv]
// Log-log interpolating lookup table. Holds up to TABLE_DEPTH points (x,y),
// unsigned Q16.16, kept sorted by x in a row of cells; an add shifts the
// cells above the insertion point up by one, all together. Items come in
// on in_data_i (command 0 add, 1 query, 2 clear, 3 no-op) and each gives
// exactly one item on out_data_o (result_value, status). A query either
// resolves on status, snaps to a segment end, or is fully interpolated by
// the math unit: five log2 evaluations (5-step leading-zero search, 16
// squarings), a restoring divider and a 16-step exp2 product. One item
// is worked at a time; the next item is accepted as soon as the current
// result has moved to the output register, even if that result has not
// yet been taken. snap_tolerance is written on the cfg channel (resets to
// 655) and must only change while idle.
module log_log_table_interpolator #(
  parameter int unsigned TABLE_DEPTH = llti_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  llti_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output llti_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [llti_pkg::TOL_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW    = llti_pkg::CRD_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_GATHER = 6'b000100,
    S_SNAP   = 6'b001000,
    S_MATH   = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e                    state_q, state_d;
  logic [1:0]                cmd_q;
  llti_pkg::point_t          item_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [llti_pkg::TOL_W-1:0] tol_q;
  logic [TABLE_DEPTH-2:0]    hit_q, hit_d;
  llti_pkg::math_req_t       seg_q, seg_d;
  logic [CW-1:0]             rval_q, rval_d;
  logic [2:0]                rst_q, rst_d;
  logic                      out_valid_q;
  llti_pkg::out_item_t       out_data_q;

  llti_pkg::point_t          pts   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]    gt, ge, vld;
  logic                      ins;
  logic                      math_start;
  logic                      math_done;
  logic [CW-1:0]             math_res;
  logic                      in_any;
  logic                      accept;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // Cell row: cell i holds the i-th smallest x. On an add every cell whose
  // x is above the new one takes its lower neighbor, or the new point if it
  // is the first such cell.
  // ---------------------------------------------------------------------
  assign ins = (state_q == S_EXEC) && (cmd_q == llti_pkg::CMD_ADD) &&
               (item_q.x != '0) && (item_q.y != '0) &&
               (count_q < CNT_W'(TABLE_DEPTH));

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign vld[i] = CNT_W'(i) < count_q;
    if (i == 0) begin : g_first
      llti_cell u_cell (
        .clk_i     (clk_i),
        .valid_i   (vld[i]),
        .ins_i     (ins),
        .new_i     (item_q),
        .prev_gt_i (1'b0),
        .prev_i    (item_q),
        .pt_o      (pts[i]),
        .gt_o      (gt[i]),
        .ge_o      (ge[i])
      );
    end else begin : g_next
      llti_cell u_cell (
        .clk_i     (clk_i),
        .valid_i   (vld[i]),
        .ins_i     (ins),
        .new_i     (item_q),
        .prev_gt_i (gt[i-1]),
        .prev_i    (pts[i-1]),
        .pt_o      (pts[i]),
        .gt_o      (gt[i]),
        .ge_o      (ge[i])
      );
    end
  end

  // x is at most the last x when some stored x is at or above it
  assign in_any = |(ge & vld);

  // First segment holding x: right end is the first stored x at or above it, from cell 1 on.
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
      hit_d[k] = ge[k+1] && vld[k+1] && ((k == 0) || !ge[k]);
    end
  end

  always_comb begin
    seg_d    = '0;
    seg_d.xq = item_q.x;
    for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
      if (hit_q[k]) begin
        seg_d.x1 = seg_d.x1 | pts[k].x;
        seg_d.y1 = seg_d.y1 | pts[k].y;
        seg_d.x2 = seg_d.x2 | pts[k+1].x;
        seg_d.y2 = seg_d.y2 | pts[k+1].y;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Item sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rval_d     = rval_q;
    rst_d      = rst_q;
    math_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        rval_d  = '0;
        rst_d   = llti_pkg::ST_OK;
        state_d = S_FINISH;
        case (cmd_q)
          llti_pkg::CMD_ADD: begin
            if (item_q.x == '0 || item_q.y == '0) begin
              rst_d = llti_pkg::ST_ZERO;
            end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
              rst_d = llti_pkg::ST_FULL;
            end else begin
              count_d = count_q + 1'b1;
            end
          end
          llti_pkg::CMD_QUERY: begin
            if (count_q < CNT_W'(2)) begin
              rst_d = llti_pkg::ST_FEW;
            end else if (item_q.x < pts[0].x || !in_any) begin
              rst_d = llti_pkg::ST_RANGE;
            end else begin
              state_d = S_GATHER;
            end
          end
          llti_pkg::CMD_CLEAR: count_d = '0;
          default: ;
        endcase
      end
      S_GATHER: state_d = S_SNAP;
      S_SNAP: begin
        if ((seg_q.xq - seg_q.x1) < CW'(tol_q)) begin
          rval_d  = seg_q.y1;
          state_d = S_FINISH;
        end else if ((seg_q.x2 - seg_q.xq) < CW'(tol_q)) begin
          rval_d  = seg_q.y2;
          state_d = S_FINISH;
        end else begin
          math_start = 1'b1;
          state_d    = S_MATH;
        end
      end
      S_MATH: begin
        if (math_done) begin
          rval_d  = math_res;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  llti_math u_math (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (math_start),
    .req_i    (seg_q),
    .done_o   (math_done),
    .result_o (math_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      tol_q       <= llti_pkg::TOL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_valid_i) tol_q <= cfg_data_i;
      if (state_q == S_FINISH && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_data_i.command;
      item_q.x <= in_data_i.x_value;
      item_q.y <= in_data_i.y_value;
    end
    hit_q  <= hit_d;
    seg_q  <= seg_d;
    rval_q <= rval_d;
    rst_q  <= rst_d;
    if (state_q == S_FINISH && (!out_valid_q || out_ready_i)) begin
      out_data_q.result_value <= rval_q;
      out_data_q.status       <= rst_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/llti_checker.sv]
module llti_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input llti_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input llti_pkg::out_item_t out_data_o
);

  // output item holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  // failed items carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != llti_pkg::ST_OK |->
      out_data_o.result_value == '0)
    else $error("error item with nonzero value");

  // an item accepted with no result pending does not raise out_valid_o straight away
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= llti_pkg::ST_ZERO)
    else $error("status code out of range");

endmodule

bind log_log_table_interpolator llti_checker u_llti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
